// ===== src/positional_shift_array_core_assert.svh =====
// Assertion macros used by the positional shift array core.
`ifndef POSITIONAL_SHIFT_ARRAY_CORE_ASSERT_SVH
`define POSITIONAL_SHIFT_ARRAY_CORE_ASSERT_SVH

// Clocked check that is switched off while reset is asserted.
`define PSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define PSA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/psa_pkg.sv =====
// Shared types and constants for the positional shift array.
`default_nettype none

package psa_pkg;

    // Default number of cells in the row.
    localparam int PSA_DEPTH = 128;

    // Cells per group in the first stage of the position select.
    localparam int PSA_GROUP = 16;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_READ   = 2'd3
    } psa_req_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADPOS = 2'd3
    } psa_status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEL,
        S_DONE
    } psa_state_t;

    // Zero-based position as carried on the row, and the width used to
    // compare it with a cell index (cell indexes reach DEPTH - 1).
    typedef logic [7:0]  psa_pidx_t;
    typedef logic [10:0] psa_cidx_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic               ins_en;
        logic               del_en;
        psa_pidx_t          pidx;
        logic signed [31:0] val;
    } psa_cmd_t;

endpackage

`default_nettype wire

// ===== src/psa_cell.sv =====
// One storage cell of the shift row: loads, shifts up or shifts down.
`default_nettype none

module psa_cell
    import psa_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  wire logic               clk,
    input  wire psa_cmd_t           cmd,
    input  wire logic signed [31:0] prev_val,
    input  wire logic signed [31:0] next_val,
    output logic signed [31:0]      val
);

    logic signed [31:0] val_reg;
    logic signed [31:0] val_next;
    psa_cidx_t          my_idx;
    psa_cidx_t          pos_idx;

    assign my_idx  = psa_cidx_t'(INDEX);
    assign pos_idx = psa_cidx_t'(cmd.pidx);

    // Insert loads the value at the position and moves later cells up;
    // delete moves the cell above down into this one.
    always_comb
    begin
        val_next = val_reg;
        if (cmd.ins_en)
        begin
            if (my_idx == pos_idx)
                val_next = cmd.val;
            else if (my_idx > pos_idx)
                val_next = prev_val;
        end
        else if (cmd.del_en)
        begin
            if (my_idx >= pos_idx)
                val_next = next_val;
        end
    end

    // Payload register, no reset needed.
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

`default_nettype wire

// ===== src/psa_select.sv =====
// Two-stage position select over the cell row: registered group muxes,
// then a final mux among the group registers.
`default_nettype none

module psa_select
    import psa_pkg::*;
#(
    parameter int DEPTH = PSA_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic signed [31:0] cell_vals [DEPTH],
    input  wire psa_pidx_t          pidx,
    output logic signed [31:0]      sel_val
);

    localparam int NGROUPS = (DEPTH + PSA_GROUP - 1) / PSA_GROUP;
    localparam int IDX_W   = $clog2(DEPTH);

    logic signed [31:0] grp_reg  [NGROUPS];
    logic signed [31:0] grp_next [NGROUPS];

    // First stage: each group picks the cell at the low position bits.
    always_comb
    begin
        int k;
        for (int g = 0; g < NGROUPS; g++)
        begin
            k = g * PSA_GROUP + int'(pidx[3:0]);
            if (k < DEPTH)
                grp_next[g] = cell_vals[IDX_W'(k)];
            else
                grp_next[g] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGROUPS; g++)
            grp_reg[g] <= grp_next[g];
    end

    // Second stage: pick the group named by the high position bits.
    always_comb
    begin
        sel_val = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            if (8'(g) == {4'b0000, pidx[7:4]})
                sel_val = grp_reg[g];
        end
    end

endmodule

`default_nettype wire

// ===== src/positional_shift_array_core.sv =====
// A request is captured at the input transaction, passes S_SEL and S_DONE, and its result is
// registered on commit in S_DONE, which waits while an unaccepted result is held. A new request
// is accepted only in S_IDLE or at that commit, as the two-stage position select reads the cell
// row before the shift is committed. Reset: rst_n clears the element count and the handshake
// state at once; cell contents are not cleared and are only read after being written.
`default_nettype none

module positional_shift_array_core
    import psa_pkg::*;
#(
    parameter int DEPTH = PSA_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         req_type,
    input  wire logic [7:0]         position,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              status,
    output logic signed [31:0]      data_out,
    output logic [7:0]              element_count
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

    psa_state_t         state_reg;
    psa_state_t         state_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    psa_req_t           req_reg;
    logic [7:0]         pos_reg;
    logic signed [31:0] val_reg;
    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] data_reg;
    logic [7:0]         ecount_reg;

    logic               accept;
    logic               commit;
    psa_status_t        stat;
    psa_cmd_t           cmd;
    psa_pidx_t          pidx;
    logic signed [31:0] sel_val;
    logic [CMPW-1:0]    pos_ext;
    logic [CMPW-1:0]    cnt_ext;
    logic signed [31:0] cell_vals [DEPTH];

    // Sequencer: next state, input ready and commit of a finished request.
    always_comb
    begin
        state_next = state_reg;
        commit     = 1'b0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = S_SEL;
            end
            S_SEL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    commit   = 1'b1;
                    in_ready = 1'b1;
                    state_next = in_valid ? S_SEL : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Request capture at the input transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= psa_req_t'(req_type);
            pos_reg <= position;
            val_reg <= value;
        end
    end

    // Request checks against the current count.
    assign pos_ext = CMPW'(pos_reg);
    assign cnt_ext = CMPW'(count_reg);
    assign pidx    = pos_reg - 8'd1;

    always_comb
    begin
        stat       = STAT_OK;
        count_next = count_reg;
        case (req_reg)
            REQ_CLEAR:
            begin
                count_next = '0;
            end
            REQ_INSERT:
            begin
                if (count_reg >= CW'(DEPTH))
                    stat = STAT_FULL;
                else if (pos_reg == 8'd0 || pos_ext > cnt_ext + CMPW'(1))
                    stat = STAT_BADPOS;
                else
                    count_next = count_reg + CW'(1);
            end
            REQ_DELETE:
            begin
                if (count_reg == '0)
                    stat = STAT_EMPTY;
                else if (pos_reg == 8'd0 || pos_ext > cnt_ext)
                    stat = STAT_BADPOS;
                else
                    count_next = count_reg - CW'(1);
            end
            REQ_READ:
            begin
                if (count_reg == '0)
                    stat = STAT_EMPTY;
                else if (pos_reg == 8'd0 || pos_ext > cnt_ext)
                    stat = STAT_BADPOS;
            end
            default:
            begin
                stat = STAT_OK;
            end
        endcase
    end

    // Command broadcast to the row; shifts happen only on commit.
    always_comb
    begin
        cmd.ins_en = commit && (stat == STAT_OK) && (req_reg == REQ_INSERT);
        cmd.del_en = commit && (stat == STAT_OK) && (req_reg == REQ_DELETE);
        cmd.pidx   = pidx;
        cmd.val    = val_reg;
    end

    // Row of cells, each linked to its neighbors.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [31:0] prev_v;
        logic signed [31:0] next_v;
        if (i == 0)
        begin : g_first
            assign prev_v = val_reg;
        end
        else
        begin : g_mid
            assign prev_v = cell_vals[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign next_v = cell_vals[i];
        end
        else
        begin : g_inner
            assign next_v = cell_vals[i+1];
        end
        psa_cell #(
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .cmd      (cmd),
            .prev_val (prev_v),
            .next_val (next_v),
            .val      (cell_vals[i])
        );
    end

    // Position select feeding delete and read results.
    psa_select #(
        .DEPTH (DEPTH)
    ) u_select (
        .clk       (clk),
        .cell_vals (cell_vals),
        .pidx      (pidx),
        .sel_val   (sel_val)
    );

    // Element count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (commit)
            count_reg <= count_next;
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload registers.
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg <= stat;
            ecount_reg <= 8'(count_next);
            if (stat == STAT_OK && (req_reg == REQ_DELETE || req_reg == REQ_READ))
                data_reg <= sel_val;
            else
                data_reg <= '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign data_out      = data_reg;
    assign element_count = ecount_reg;

`include "positional_shift_array_core_assert.svh"

    `PSA_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "element count exceeds depth")
    `PSA_ASSERT(a_count_only_on_commit, !$past(commit) |-> $stable(count_reg), "count moved without commit")
    `PSA_ASSERT(a_out_rise_from_done, $rose(out_valid_reg) |-> $past(state_reg == S_DONE), "result raised outside done state")
    `PSA_ASSERT_ALWAYS(a_reset_count, !rst_n && !$past(rst_n) |-> count_reg == '0, "count not cleared in reset")

endmodule

`default_nettype wire
